// File: hw/rtl/bctp_pkg.sv
// Shared types and constants of the binarized convolution, threshold and pooling unit.
package bctp_pkg;

	localparam int DEF_MAX_CHANNELS = 1024;
	localparam int DEF_ACC_WIDTH    = 32;

	localparam int POS_W    = 12;
	localparam int OFF_W    = 5;
	localparam int WORD_W   = POS_W - OFF_W;
	localparam int NCH_W    = 11;
	localparam int POOL_W   = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 11;
	localparam int RES_DEPTH = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NUM_CHANNELS = 2'd0,
		CFG_POOL_WINDOW  = 2'd1
	} cfg_index_t;

	typedef struct packed {
		logic signed [7:0]  act_first;
		logic signed [7:0]  act_second;
		logic signed [7:0]  weight;
		logic signed [15:0] threshold;
		logic               channel_end;
		logic               row_start;
		logic [OFF_W-1:0]   bit_offset;
		logic [POOL_W-1:0]  pool_count;
	} in_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] word_index;
		logic [OFF_W-1:0]  bit_index;
		logic              bit_value;
		logic              time_step;
		logic              last;
	} out_item_t;

	typedef struct packed {
		logic fire;
		logic row_start;
		logic channel_end;
	} step_ctrl_t;

endpackage

// File: hw/rtl/binary_conv_threshold_pool_unit.sv
// Top level of the binarized convolution, threshold and pooling unit.
//
// Channel   Handshake              Payload
// src       src_valid / src_stall  src_data   (bctp_pkg::in_item_t)
// dst       dst_valid / dst_stall  dst_data   (bctp_pkg::out_item_t)
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A request is registered on acceptance and processed in the next cycle, so one
// request per cycle is taken while src_stall is low. The accumulator and position
// updates close in the same cycle. A request that ends a channel queues two results;
// the output drains one per cycle while dst_stall is low and sets the channel-end rate.
// Reset clears accumulators, positions and the result queue; cfg_ready is always high.
// A stalled output only holds the input off when the queue has no room for a pair.
module binary_conv_threshold_pool_unit #(
	parameter int MAX_CHANNELS = bctp_pkg::DEF_MAX_CHANNELS,
	parameter int ACC_WIDTH    = bctp_pkg::DEF_ACC_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              src_valid,
	output logic                              src_stall,
	input  bctp_pkg::in_item_t                src_data,
	output logic                              dst_valid,
	input  logic                              dst_stall,
	output bctp_pkg::out_item_t               dst_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bctp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bctp_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic                          valid_s1;
	bctp_pkg::in_item_t            item_s1;
	logic [bctp_pkg::NCH_W-1:0]    num_channels_q;
	logic [bctp_pkg::POOL_W-1:0]   pool_window_q;
	bctp_pkg::step_ctrl_t          ctrl;
	logic                          room_pair;
	logic                          advance;
	logic                          bit_first;
	logic                          bit_second;
	logic [bctp_pkg::POS_W-1:0]    pos_first;
	logic [bctp_pkg::POS_W-1:0]    pos_second;
	bctp_pkg::out_item_t           res_first;
	bctp_pkg::out_item_t           res_second;
	logic                          pop;
	logic [2:0]                    res_count;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_channels_q <= bctp_pkg::NCH_W'(1);
			pool_window_q  <= bctp_pkg::POOL_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bctp_pkg::CFG_NUM_CHANNELS: begin
					num_channels_q <= cfg_data[bctp_pkg::NCH_W-1:0];
				end
				bctp_pkg::CFG_POOL_WINDOW: begin
					pool_window_q <= cfg_data[bctp_pkg::POOL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		advance          = valid_s1 && (!item_s1.channel_end || room_pair);
		src_stall        = valid_s1 && !advance;
		ctrl.fire        = advance;
		ctrl.row_start   = item_s1.row_start;
		ctrl.channel_end = item_s1.channel_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!src_stall) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!src_stall && src_valid) begin
			item_s1 <= src_data;
		end
	end

	bctp_mac #(
		.ACC_WIDTH (ACC_WIDTH)
	) u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.act_first  (item_s1.act_first),
		.act_second (item_s1.act_second),
		.weight     (item_s1.weight),
		.threshold  (item_s1.threshold),
		.bit_first  (bit_first),
		.bit_second (bit_second)
	);

	bctp_pos #(
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_pos (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.bit_offset   (item_s1.bit_offset),
		.pool_count   (item_s1.pool_count),
		.num_channels (num_channels_q),
		.pool_window  (pool_window_q),
		.pos_first    (pos_first),
		.pos_second   (pos_second)
	);

	always_comb begin
		res_first.word_index  = pos_first[bctp_pkg::POS_W-1:bctp_pkg::OFF_W];
		res_first.bit_index   = ~pos_first[bctp_pkg::OFF_W-1:0];
		res_first.bit_value   = bit_first;
		res_first.time_step   = 1'b0;
		res_first.last        = 1'b0;
		res_second.word_index = pos_second[bctp_pkg::POS_W-1:bctp_pkg::OFF_W];
		res_second.bit_index  = ~pos_second[bctp_pkg::OFF_W-1:0];
		res_second.bit_value  = bit_second;
		res_second.time_step  = 1'b1;
		res_second.last       = 1'b1;
		pop                   = dst_valid && !dst_stall;
	end

	bctp_res_fifo u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_pair (advance && item_s1.channel_end),
		.item_a    (res_first),
		.item_b    (res_second),
		.pop       (pop),
		.head      (dst_data),
		.not_empty (dst_valid),
		.room_pair (room_pair),
		.count     (res_count)
	);

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_count <= 3'(bctp_pkg::RES_DEPTH))
		else $error("result queue holds more than its depth");

	a_pair_push: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.channel_end && !pop |=> res_count == $past(res_count) + 3'd2)
		else $error("channel end did not queue a result pair");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !dst_data.last |=> dst_valid && dst_data.last)
		else $error("first result of a pair not followed by its second");

	a_stall_needs_work: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> valid_s1 && item_s1.channel_end && !room_pair)
		else $error("input held off without a full result queue");

endmodule

// File: hw/rtl/bctp_mac.sv
// Two multiply-accumulate lanes with the threshold compare at a channel's end.
module bctp_mac #(
	parameter int ACC_WIDTH = bctp_pkg::DEF_ACC_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bctp_pkg::step_ctrl_t ctrl,
	input  logic signed [7:0]    act_first,
	input  logic signed [7:0]    act_second,
	input  logic signed [7:0]    weight,
	input  logic signed [15:0]   threshold,
	output logic                 bit_first,
	output logic                 bit_second
);

	logic signed [ACC_WIDTH-1:0] acc_first_q;
	logic signed [ACC_WIDTH-1:0] acc_second_q;
	logic signed [15:0]          prod_first;
	logic signed [15:0]          prod_second;
	logic signed [ACC_WIDTH-1:0] base_first;
	logic signed [ACC_WIDTH-1:0] base_second;
	logic signed [ACC_WIDTH-1:0] sum_first;
	logic signed [ACC_WIDTH-1:0] sum_second;
	logic signed [ACC_WIDTH-1:0] thr_ext;

	always_comb begin
		prod_first  = act_first * weight;
		prod_second = act_second * weight;
		base_first  = ctrl.row_start ? '0 : acc_first_q;
		base_second = ctrl.row_start ? '0 : acc_second_q;
		sum_first   = base_first + ACC_WIDTH'(prod_first);
		sum_second  = base_second + ACC_WIDTH'(prod_second);
		thr_ext     = ACC_WIDTH'(threshold);
		bit_first   = sum_first >= thr_ext;
		bit_second  = sum_second >= thr_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_first_q  <= '0;
			acc_second_q <= '0;
		end else if (ctrl.fire) begin
			acc_first_q  <= ctrl.channel_end ? '0 : sum_first;
			acc_second_q <= ctrl.channel_end ? '0 : sum_second;
		end
	end

endmodule

// File: hw/rtl/bctp_pos.sv
// Running bit positions of both time steps, with the pooling displacement.
module bctp_pos #(
	parameter int MAX_CHANNELS = bctp_pkg::DEF_MAX_CHANNELS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bctp_pkg::step_ctrl_t           ctrl,
	input  logic [bctp_pkg::OFF_W-1:0]     bit_offset,
	input  logic [bctp_pkg::POOL_W-1:0]    pool_count,
	input  logic [bctp_pkg::NCH_W-1:0]     num_channels,
	input  logic [bctp_pkg::POOL_W-1:0]    pool_window,
	output logic [bctp_pkg::POS_W-1:0]     pos_first,
	output logic [bctp_pkg::POS_W-1:0]     pos_second
);

	localparam int CH_W = bctp_pkg::POS_W + 1;
	localparam logic [CH_W-1:0] MAX_CH = CH_W'(MAX_CHANNELS);

	logic [bctp_pkg::POS_W-1:0]  pos_first_q;
	logic [bctp_pkg::POS_W-1:0]  pos_second_q;
	logic [bctp_pkg::POOL_W-1:0] count_inc;
	logic [CH_W-1:0]             nch_ext;
	logic [CH_W-1:0]             ch_sat;
	logic [bctp_pkg::POS_W-1:0]  disp;
	logic [bctp_pkg::POS_W-1:0]  off_ext;

	always_comb begin
		count_inc = pool_count + 1'b1;
		nch_ext   = CH_W'(num_channels);
		ch_sat    = (nch_ext > MAX_CH) ? MAX_CH : nch_ext;
		disp      = (count_inc > pool_window) ? ch_sat[bctp_pkg::POS_W-1:0] : '0;
		off_ext   = bctp_pkg::POS_W'(bit_offset);
		pos_first  = ctrl.row_start ? off_ext : pos_first_q;
		pos_second = ctrl.row_start ? off_ext + disp : pos_second_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_first_q  <= '0;
			pos_second_q <= '0;
		end else if (ctrl.fire) begin
			pos_first_q  <= ctrl.channel_end ? pos_first + 1'b1 : pos_first;
			pos_second_q <= ctrl.channel_end ? pos_second + 1'b1 : pos_second;
		end
	end

endmodule

// File: hw/rtl/bctp_res_fifo.sv
// Small result queue that takes a pair of results at once and hands out one per cycle when popped.
module bctp_res_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_pair,
	input  bctp_pkg::out_item_t item_a,
	input  bctp_pkg::out_item_t item_b,
	input  logic                pop,
	output bctp_pkg::out_item_t head,
	output logic                not_empty,
	output logic                room_pair,
	output logic [2:0]          count
);

	localparam int PTR_W = $clog2(bctp_pkg::RES_DEPTH);

	bctp_pkg::out_item_t mem [bctp_pkg::RES_DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [2:0]          count_q;
	logic [PTR_W-1:0]    wr_ptr_b;

	always_comb begin
		wr_ptr_b  = wr_ptr_q + 1'b1;
		head      = mem[rd_ptr_q];
		not_empty = count_q != '0;
		room_pair = count_q <= 3'(bctp_pkg::RES_DEPTH - 2);
		count     = count_q;
	end

	always_ff @(posedge clk) begin
		if (push_pair) begin
			mem[wr_ptr_q] <= item_a;
			mem[wr_ptr_b] <= item_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_pair) begin
				wr_ptr_q <= wr_ptr_q + 2'd2;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (push_pair ? 3'd2 : 3'd0) - (pop ? 3'd1 : 3'd0);
		end
	end

endmodule

// File: tb/bctp_checker.sv
// Checker that predicts the unit's bit writes from observed requests and compares them.
module bctp_checker #(
	parameter int MAX_CHANNELS = bctp_pkg::DEF_MAX_CHANNELS,
	parameter int ACC_WIDTH    = bctp_pkg::DEF_ACC_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            src_valid,
	input  logic                            src_stall,
	input  bctp_pkg::in_item_t              src_data,
	input  logic                            dst_valid,
	input  logic                            dst_stall,
	input  bctp_pkg::out_item_t             dst_data,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [bctp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bctp_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              fail_count,
	output int                              pending
);

	logic [ACC_WIDTH-1:0]             acc_t0;
	logic [ACC_WIDTH-1:0]             acc_t1;
	logic [bctp_pkg::POS_W-1:0]       pos_t0;
	logic [bctp_pkg::POS_W-1:0]       pos_t1;
	logic [bctp_pkg::NCH_W-1:0]       num_channels;
	logic [bctp_pkg::POOL_W-1:0]      pool_window;
	bctp_pkg::out_item_t              bit_writes_due[$];
	int                               errors = 0;

	function automatic bctp_pkg::out_item_t bit_write(input logic [bctp_pkg::POS_W-1:0] pos,
			input logic hit, input logic step);
		bctp_pkg::out_item_t w;
		w.word_index = pos[bctp_pkg::POS_W-1:bctp_pkg::OFF_W];
		w.bit_index  = ~pos[bctp_pkg::OFF_W-1:0];
		w.bit_value  = hit;
		w.time_step  = step;
		w.last       = step;
		return w;
	endfunction

	task automatic predict_bit_writes(input bctp_pkg::in_item_t req);
		logic [bctp_pkg::NCH_W-1:0]  chans;
		logic [bctp_pkg::POOL_W-1:0] pooled;
		logic signed [15:0]          prod_t0;
		logic signed [15:0]          prod_t1;
		if (req.row_start) begin
			chans  = (num_channels > MAX_CHANNELS) ? bctp_pkg::NCH_W'(MAX_CHANNELS)
				: num_channels;
			pooled = req.pool_count + 1'b1;
			pos_t0 = bctp_pkg::POS_W'(req.bit_offset);
			pos_t1 = bctp_pkg::POS_W'(req.bit_offset)
				+ ((pooled > pool_window) ? bctp_pkg::POS_W'(chans) : '0);
			acc_t0 = '0;
			acc_t1 = '0;
		end
		prod_t0 = $signed(req.act_first) * $signed(req.weight);
		prod_t1 = $signed(req.act_second) * $signed(req.weight);
		acc_t0 = acc_t0 + {{(ACC_WIDTH-16){prod_t0[15]}}, prod_t0};
		acc_t1 = acc_t1 + {{(ACC_WIDTH-16){prod_t1[15]}}, prod_t1};
		if (req.channel_end) begin
			bit_writes_due.push_back(bit_write(pos_t0,
				$signed(acc_t0) >= $signed(req.threshold), 1'b0));
			bit_writes_due.push_back(bit_write(pos_t1,
				$signed(acc_t1) >= $signed(req.threshold), 1'b1));
			pos_t0 = pos_t0 + 1'b1;
			pos_t1 = pos_t1 + 1'b1;
			acc_t0 = '0;
			acc_t1 = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		bctp_pkg::out_item_t want;
		if (!arst_n) begin
			acc_t0       = '0;
			acc_t1       = '0;
			pos_t0       = '0;
			pos_t1       = '0;
			num_channels = bctp_pkg::NCH_W'(1);
			pool_window  = bctp_pkg::POOL_W'(1);
			bit_writes_due.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					bctp_pkg::CFG_NUM_CHANNELS: num_channels = cfg_data[bctp_pkg::NCH_W-1:0];
					bctp_pkg::CFG_POOL_WINDOW:  pool_window  = cfg_data[bctp_pkg::POOL_W-1:0];
					default: ;
				endcase
			end
			if (src_valid && !src_stall)
				predict_bit_writes(src_data);
			if (dst_valid && !dst_stall) begin
				if (bit_writes_due.size() == 0) begin
					$error("bit write with none pending: word_index %0d bit_index %0d",
						dst_data.word_index, dst_data.bit_index);
					errors++;
				end else begin
					want = bit_writes_due.pop_front();
					if (dst_data.word_index !== want.word_index) begin
						$error("word_index: expected %0d, actual %0d",
							want.word_index, dst_data.word_index);
						errors++;
					end
					if (dst_data.bit_index !== want.bit_index) begin
						$error("bit_index: expected %0d, actual %0d",
							want.bit_index, dst_data.bit_index);
						errors++;
					end
					if (dst_data.bit_value !== want.bit_value) begin
						$error("bit_value: expected %0d, actual %0d",
							want.bit_value, dst_data.bit_value);
						errors++;
					end
					if (dst_data.time_step !== want.time_step) begin
						$error("time_step: expected %0d, actual %0d",
							want.time_step, dst_data.time_step);
						errors++;
					end
					if (dst_data.last !== want.last) begin
						$error("last: expected %0d, actual %0d", want.last, dst_data.last);
						errors++;
					end
				end
			end
			fail_count <= errors;
			pending    <= bit_writes_due.size();
		end
	end

endmodule

// File: tb/testbench.sv
// Top of the testbench: clock, reset, request stimulus, result sink and verdict.
module testbench;

	localparam int HALF_HIGH      = 5;
	localparam int HALF_LOW       = 5;
	localparam int RESET_CYCLES   = 9;
	localparam int IDLE_SETTLE    = 8;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_PHASES  = 8;
	localparam int FIXED_PHASES   = 6;
	localparam int PHASE_ITEMS    = 120;
	localparam int LONG_ROW_ITEMS = 600;
	localparam logic [bctp_pkg::CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            src_valid;
	logic                            src_stall;
	bctp_pkg::in_item_t              src_data;
	logic                            dst_valid;
	logic                            dst_stall;
	bctp_pkg::out_item_t             dst_data;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [bctp_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [bctp_pkg::CFG_DATA_W-1:0] cfg_data;
	int                              fail_count;
	int                              pending;
	int                              idle_cycles = 0;
	bit                              hold_wanted = 1'b0;

	binary_conv_threshold_pool_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_data  (src_data),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_data  (dst_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	bctp_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.src_valid  (src_valid),
		.src_stall  (src_stall),
		.src_data   (src_data),
		.dst_valid  (dst_valid),
		.dst_stall  (dst_stall),
		.dst_data   (dst_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#HALF_LOW clk = 1'b1;
		#HALF_HIGH clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((src_valid && !src_stall) || (dst_valid && !dst_stall)
					|| (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	function automatic int src_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 7))
			0: return 8'h80;
			1: return 8'h7f;
			2: return 8'hff;
			3: return 8'h00;
			default: return 8'($urandom());
		endcase
	endfunction

	function automatic logic [15:0] rand_threshold();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 16'h8000;
		if (r < 20)
			return 16'h7fff;
		if (r < 55)
			return 16'($urandom());
		return 16'(int'($urandom_range(0, 8000)) - 4000);
	endfunction

	function automatic bctp_pkg::in_item_t random_item();
		bctp_pkg::in_item_t it;
		it.act_first   = rand_byte();
		it.act_second  = rand_byte();
		it.weight      = rand_byte();
		it.threshold   = rand_threshold();
		it.channel_end = 1'b0;
		it.row_start   = 1'b0;
		it.bit_offset  = 5'($urandom());
		it.pool_count  = 8'($urandom());
		return it;
	endfunction

	function automatic bctp_pkg::in_item_t item_of(input int a1, a2, w, thr, input bit ce, rs,
			input int off, pc);
		bctp_pkg::in_item_t it;
		it.act_first   = 8'(a1);
		it.act_second  = 8'(a2);
		it.weight      = 8'(w);
		it.threshold   = 16'(thr);
		it.channel_end = ce;
		it.row_start   = rs;
		it.bit_offset  = 5'(off);
		it.pool_count  = 8'(pc);
		return it;
	endfunction

	function automatic logic [7:0] pick_pool_count(input logic [7:0] pw);
		case ($urandom_range(0, 5))
			0: return pw - 1'b1;
			1: return pw;
			2: return pw + 1'b1;
			3: return 8'hff;
			4: return 8'h00;
			default: return 8'($urandom());
		endcase
	endfunction

	task automatic send(input bctp_pkg::in_item_t it, input int gap);
		repeat (gap) begin
			@(negedge clk);
			src_valid <= 1'b0;
		end
		@(negedge clk);
		src_valid <= 1'b1;
		src_data  <= it;
		do @(posedge clk); while (src_stall);
	endtask

	task automatic drain();
		@(negedge clk);
		src_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (IDLE_SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [bctp_pkg::CFG_IDX_W-1:0] idx,
			input logic [bctp_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// A row is a request with row start followed by channels of one to six kernel elements;
	// a few requests get random framing bits to break the sequence.
	task automatic send_row(input logic [7:0] pw, inout int sent);
		int chans;
		int klen;
		bctp_pkg::in_item_t it;
		chans = $urandom_range(1, 8);
		for (int c = 0; c < chans; c++) begin
			klen = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 6);
			for (int k = 0; k < klen; k++) begin
				it = random_item();
				it.row_start   = (c == 0 && k == 0);
				it.channel_end = (k == klen - 1);
				if (it.row_start)
					it.pool_count = pick_pool_count(pw);
				if ($urandom_range(0, 99) < 8) begin
					it.row_start   = 1'($urandom());
					it.channel_end = 1'($urandom());
				end
				send(it, src_gap());
				sent++;
			end
		end
	endtask

	initial begin : result_sink
		int free_len;
		int stall_len;
		int r;
		dst_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			r = $urandom_range(0, 99);
			free_len = (r < 10) ? $urandom_range(30, 80) : $urandom_range(1, 6);
			@(negedge clk);
			dst_stall <= 1'b0;
			repeat (free_len - 1) @(negedge clk);
			if (hold_wanted) begin
				hold_wanted = 1'b0;
				stall_len = HOLD_CYCLES;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 75)
					stall_len = $urandom_range(1, 3);
				else if (r < 95)
					stall_len = $urandom_range(4, 12);
				else
					stall_len = $urandom_range(20, 60);
			end
			@(negedge clk);
			dst_stall <= 1'b1;
			repeat (stall_len - 1) @(negedge clk);
		end
	end

	initial begin : stimulus
		int nch_set[FIXED_PHASES];
		int pw_set[FIXED_PHASES];
		logic [bctp_pkg::NCH_W-1:0]  nch;
		logic [bctp_pkg::POOL_W-1:0] pw;
		bctp_pkg::in_item_t it;
		int sent;
		nch_set   = '{0, 1024, 2047, 1025, 3, 1};
		pw_set    = '{0, 255, 1, 128, 0, 255};
		arst_n    = 1'b0;
		src_valid = 1'b0;
		src_data  = '0;
		cfg_valid = 1'b0;
		cfg_index = bctp_pkg::CFG_NUM_CHANNELS;
		cfg_data  = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// Reset settings; the first two requests come before any row start.
		send(item_of(127, 127, 127, 32767, 1, 0, 0, 0), 0);
		send(item_of(-128, -128, -128, -32768, 1, 0, 31, 255), 0);
		send(item_of(10, 9, 10, 100, 1, 1, 0, 0), 0);
		send(item_of(-128, 127, 127, 0, 0, 1, 31, 1), 0);
		send(item_of(1, -1, -1, -16257, 1, 0, 0, 0), 1);
		send(item_of(0, 0, 0, -1, 1, 0, 0, 0), 0);
		send(item_of(-1, -1, 1, 0, 1, 1, 5, 255), 2);
		send(item_of(127, -128, -1, 127, 1, 1, 16, 0), 0);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph < FIXED_PHASES) begin
				nch = bctp_pkg::NCH_W'(nch_set[ph]);
				pw  = bctp_pkg::POOL_W'(pw_set[ph]);
			end else begin
				nch = $urandom_range(0, 1) ? bctp_pkg::NCH_W'($urandom_range(1, 64))
					: bctp_pkg::NCH_W'($urandom_range(0, 2047));
				pw  = bctp_pkg::POOL_W'($urandom());
			end
			drain();
			write_reg(bctp_pkg::CFG_NUM_CHANNELS, nch);
			write_reg(bctp_pkg::CFG_POOL_WINDOW, {3'($urandom()), pw});
			if (ph == 0)
				write_reg(CFG_SPARE_INDEX, '1);
			// Pool counts on either side of the window edge.
			it = random_item();
			it.row_start   = 1'b1;
			it.channel_end = 1'b1;
			it.pool_count  = pw - 1'b1;
			send(it, 0);
			it.pool_count  = pw;
			send(it, 0);
			sent = 0;
			while (sent < PHASE_ITEMS)
				send_row(pw, sent);
		end

		// One long row of channel ends at the largest displacement, while the sink
		// holds off long enough for the unit to fill up and stall its input.
		drain();
		write_reg(bctp_pkg::CFG_NUM_CHANNELS, '1);
		write_reg(bctp_pkg::CFG_POOL_WINDOW, '0);
		it = random_item();
		it.row_start   = 1'b1;
		it.channel_end = 1'b1;
		it.bit_offset  = 5'd31;
		it.pool_count  = 8'd0;
		send(it, 0);
		hold_wanted = 1'b1;
		for (int i = 0; i < LONG_ROW_ITEMS; i++) begin
			it = random_item();
			it.channel_end = 1'b1;
			send(it, 0);
		end

		drain();
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// File: binary_conv_threshold_pool_unit.f
hw/rtl/bctp_pkg.sv
hw/rtl/bctp_mac.sv
hw/rtl/bctp_pos.sv
hw/rtl/bctp_res_fifo.sv
hw/rtl/binary_conv_threshold_pool_unit.sv
tb/bctp_checker.sv
tb/testbench.sv
